/* hdl/efsd_pkg.sv */
// efsd_pkg: shared constants and control types for the earliest free server dispatcher
// used by efsd_ctrl, efsd_dp and earliest_free_server_dispatcher_core
// no dependencies
package efsd_pkg;

  // built server count and derived widths
  localparam int MAX_SERVERS = 16;
  localparam int SRV_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

  // field widths of the words
  localparam int TIME_W  = 32;
  localparam int LOAD_W  = 16;
  localparam int IDX_W   = 4;
  localparam int ACT_W   = 5;

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_ACTIVE = 2'd0;
  localparam logic [ACT_W-1:0]      ACTIVE_RESET    = 5'd1;

  // controller to datapath commands
  typedef struct packed {
    logic load_job;   // capture the incoming word, restart the scan
    logic scan;       // examine one server this cycle
    logic update;     // commit the chosen server and load the result
  } efsd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // current scan slot is the last active server
  } efsd_stat_t;

endpackage

/* hdl/efsd_ctrl.sv */
// efsd_ctrl: sequencer for one job at a time: accept, scan servers, commit
// depends on efsd_pkg
module efsd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  efsd_pkg::efsd_stat_t  stat,
  output efsd_pkg::efsd_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  // result register is free, or is being emptied this cycle
  assign commit = (state_r == ST_UPD) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: if (stat.scan_last) state_nxt = ST_UPD;
      ST_UPD:  if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // handshake and commands
  assign in_tready    = (state_r == ST_IDLE);
  assign out_tvalid   = out_valid_r;
  assign cmd.load_job = (state_r == ST_IDLE) && in_tvalid;
  assign cmd.scan     = (state_r == ST_SCAN);
  assign cmd.update   = commit;

endmodule

/* hdl/efsd_dp.sv */
// efsd_dp: server state, sequential minimum search and finish time update
// depends on efsd_pkg
module efsd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  efsd_pkg::efsd_cmd_t                 cmd,
  output efsd_pkg::efsd_stat_t                stat,
  input  logic [efsd_pkg::CNT_W-1:0]          srv_count,
  input  logic [efsd_pkg::TIME_W-1:0]         arrival_time,
  input  logic [efsd_pkg::LOAD_W-1:0]         job_load,
  output logic [efsd_pkg::IDX_W-1:0]          server_index,
  output logic [efsd_pkg::TIME_W-1:0]         finish_time
);

  // server state
  logic [efsd_pkg::TIME_W-1:0] finish_r [efsd_pkg::MAX_SERVERS];
  logic [efsd_pkg::MAX_SERVERS-1:0] busy_r;

  // job word
  logic [efsd_pkg::TIME_W-1:0] arr_r;
  logic [efsd_pkg::LOAD_W-1:0] load_r;

  // scan registers
  logic [efsd_pkg::SRV_W-1:0]  idx_r;
  logic                        have_free_r;
  logic [efsd_pkg::SRV_W-1:0]  bf_idx_r, ba_idx_r;
  logic [efsd_pkg::TIME_W-1:0] bf_fin_r, ba_fin_r;

  // result registers
  logic [efsd_pkg::IDX_W-1:0]  res_idx_r;
  logic [efsd_pkg::TIME_W-1:0] res_fin_r;

  // current slot
  logic [efsd_pkg::TIME_W-1:0] cur_fin;
  logic                        expired, cur_free, take_free, take_any;

  assign cur_fin   = finish_r[idx_r];
  assign expired   = arr_r > cur_fin;
  assign cur_free  = !busy_r[idx_r] || expired;
  assign take_free = cur_free && (!have_free_r || (cur_fin < bf_fin_r));
  assign take_any  = (idx_r == '0) || (cur_fin < ba_fin_r);

  assign stat.scan_last = (idx_r == efsd_pkg::SRV_W'(srv_count - 1'b1));

  // chosen server and its new finish time
  logic [efsd_pkg::SRV_W-1:0]  pick;
  logic [efsd_pkg::TIME_W-1:0] pick_fin, base;
  logic [efsd_pkg::TIME_W:0]   sum;
  logic [efsd_pkg::TIME_W-1:0] new_fin;

  assign pick     = have_free_r ? bf_idx_r : ba_idx_r;
  assign pick_fin = have_free_r ? bf_fin_r : ba_fin_r;
  assign base     = (arr_r > pick_fin) ? arr_r : pick_fin;
  assign sum      = {1'b0, base} + {{(efsd_pkg::TIME_W + 1 - efsd_pkg::LOAD_W){1'b0}}, load_r};
  assign new_fin  = sum[efsd_pkg::TIME_W] ? {efsd_pkg::TIME_W{1'b1}}
                                          : sum[efsd_pkg::TIME_W-1:0];

  // server finish times and busy marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      for (int k = 0; k < efsd_pkg::MAX_SERVERS; k++) begin
        finish_r[k] <= '0;
      end
    end else if (cmd.scan) begin
      if (expired) begin
        busy_r[idx_r] <= 1'b0;
      end
    end else if (cmd.update) begin
      busy_r[pick]   <= 1'b1;
      finish_r[pick] <= new_fin;
    end
  end

  // scan slot counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load_job) begin
      idx_r <= '0;
    end else if (cmd.scan && !stat.scan_last) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // job capture and running minima
  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      arr_r       <= arrival_time;
      load_r      <= job_load;
      have_free_r <= 1'b0;
    end else if (cmd.scan) begin
      if (take_free) begin
        have_free_r <= 1'b1;
        bf_idx_r    <= idx_r;
        bf_fin_r    <= cur_fin;
      end
      if (take_any) begin
        ba_idx_r <= idx_r;
        ba_fin_r <= cur_fin;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_idx_r <= efsd_pkg::IDX_W'(pick);
      res_fin_r <= new_fin;
    end
  end

  assign server_index = res_idx_r;
  assign finish_time  = res_fin_r;

endmodule

/* hdl/earliest_free_server_dispatcher_core.sv */
// earliest_free_server_dispatcher_core: dispatches each job word to the earliest free server
// operation: the accepted word is scanned one server per cycle over n active servers (1..16), then committed
// a new word is accepted only after the last is committed, and the commit waits while a result is not taken
// reset: synchronous active-low rst_n; all servers free with finish time zero, one active
// depends on efsd_pkg, efsd_ctrl, efsd_dp
module earliest_free_server_dispatcher_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [efsd_pkg::IN_DATA_W-1:0]       in_tdata,   // arrival_time[31:0], job_load[47:32]
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [efsd_pkg::OUT_DATA_W-1:0]      out_tdata,  // server_index[3:0], finish_time[35:4], zero pad
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [efsd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [efsd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [efsd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  // active server register
  logic [efsd_pkg::ACT_W-1:0] active_r, active_nxt;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == efsd_pkg::CFG_ADDR_ACTIVE);
  assign active_nxt = cfg_wr ? cfg_pwdata[efsd_pkg::ACT_W-1:0] : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= efsd_pkg::ACTIVE_RESET;
    end else begin
      active_r <= active_nxt;
    end
  end

  // register read back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == efsd_pkg::CFG_ADDR_ACTIVE) begin
      cfg_prdata = efsd_pkg::CFG_DATA_W'(active_r);
    end
  end

  // clamp to 1..MAX_SERVERS
  logic [efsd_pkg::CNT_W-1:0] srv_count;

  always_comb begin
    priority if (active_r == '0) begin
      srv_count = efsd_pkg::CNT_W'(1);
    end else if (int'(active_r) > efsd_pkg::MAX_SERVERS) begin
      srv_count = efsd_pkg::CNT_W'(efsd_pkg::MAX_SERVERS);
    end else begin
      srv_count = efsd_pkg::CNT_W'(active_r);
    end
  end

  // controller and datapath
  efsd_pkg::efsd_cmd_t  cmd;
  efsd_pkg::efsd_stat_t stat;
  logic [efsd_pkg::IDX_W-1:0]  server_index;
  logic [efsd_pkg::TIME_W-1:0] finish_time;

  efsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  efsd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .srv_count    (srv_count),
    .arrival_time (in_tdata[efsd_pkg::TIME_W-1:0]),
    .job_load     (in_tdata[efsd_pkg::TIME_W +: efsd_pkg::LOAD_W]),
    .server_index (server_index),
    .finish_time  (finish_time)
  );

  // result word packing
  assign out_tdata = {{(efsd_pkg::OUT_DATA_W - efsd_pkg::TIME_W - efsd_pkg::IDX_W){1'b0}},
                      finish_time, server_index};

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is in flight");

  // a result never appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result raised too early after accept");

  // chosen server lies among the active ones
  a_index_active: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (efsd_pkg::CNT_W'(server_index) < srv_count))
    else $error("dispatched to an inactive server");

endmodule
